### rtl/summed_area_rect_query_core_defines.svh
// Assertion macros for the summed-area query core.
// SAT_ASSERT checks outside reset; SAT_ASSERT_ALWAYS checks on every clock edge.
`ifndef SUMMED_AREA_RECT_QUERY_CORE_DEFINES_SVH
`define SUMMED_AREA_RECT_QUERY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SAT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sat assertion failed");
`define SAT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sat assertion failed");
`else
`define SAT_ASSERT(lbl, prop)
`define SAT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### rtl/sat_pkg.sv
`timescale 1ns / 1ps
package sat_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = ROW_W + COL_W;

  localparam int DIM_W     = 7;
  localparam int VAL_W     = 16;
  localparam int SUM_W     = 28;
  localparam int CNT_W     = 2 * DIM_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] GRID_RESET = DIM_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    sum_t              wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Saturate a dimension register into 1..maxv.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      res = DIM_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

### rtl/sat_prefix_mem.sv
`timescale 1ns / 1ps
module sat_prefix_mem
  import sat_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output sum_t     rdata_o
);

  localparam int DEPTH = 2 ** ADDR_W;

  sum_t mem_q [DEPTH];
  sum_t rdata_q;

  // Read returns the old word on a same-address write; the sequencer never needs the new one.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/summed_area_rect_query_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      opcode_i, cell_value_i, top_row_i,
//                                                left_col_i, bottom_row_i, right_col_i
// result    out        done_o, one cycle         all_covered_o, rect_sum_o, bad_query_o
// config    in         cfg_valid_i & cfg_ready_o cfg_index_i, cfg_wdata_i
//
// A load reads the word above from the prefix RAM at accept and writes the new entry
// in the next cycle. A valid query makes four reads of the single RAM read port, then
// the final add; done_o rises in the cycle after that add. A rejected query raises
// done_o in the cycle after accept. Reset clears the load position, row sum and ready
// flag; the RAM holds garbage until loaded. The result cannot be stalled by the receiver.
`include "summed_area_rect_query_core_defines.svh"
module summed_area_rect_query_core
  import sat_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 opcode_i,
  input  logic signed [VAL_W-1:0] cell_value_i,
  input  logic [DIM_W-1:0]     top_row_i,
  input  logic [DIM_W-1:0]     left_col_i,
  input  logic [DIM_W-1:0]     bottom_row_i,
  input  logic [DIM_W-1:0]     right_col_i,
  output logic                 done_o,
  output logic                 all_covered_o,
  output logic signed [SUM_W-1:0] rect_sum_o,
  output logic                 bad_query_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LD_WR = 6'b000010,
    ST_Q_RD1 = 6'b000100,
    ST_Q_RD2 = 6'b001000,
    ST_Q_RD3 = 6'b010000,
    ST_Q_FIN = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [DIM_W-1:0] grid_rows_q, grid_rows_d, grid_cols_q, grid_cols_d;
  logic [ROW_W-1:0] load_row_q, load_row_d;
  logic [COL_W-1:0] load_col_q, load_col_d;
  sum_t             rsum_q, rsum_d;
  logic             ready_q, ready_d;
  logic             done_q, done_d;

  logic [ROW_W-1:0] b0_q, b0_d, tm1_q, tm1_d;
  logic [COL_W-1:0] r0_q, r0_d, lm1_q, lm1_d;
  logic             t_nz_q, t_nz_d, l_nz_q, l_nz_d;
  logic [DIM_W-1:0] h_q, h_d, w_q, w_d;
  logic [CNT_W-1:0] count_q, count_d;
  sum_t             acc_q, acc_d;
  logic             cover_q, cover_d, bad_q, bad_d;
  sum_t             sum_q, sum_d;

  mem_req_t         mem_req;
  sum_t             rdata;

  logic             accept, cfg_wr, restart, bad_cmd;
  logic [DIM_W-1:0] rows, cols;
  logic [ROW_W-1:0] eff_row;
  logic [COL_W-1:0] eff_col;
  sum_t             ext_val, fin_sum;

  sat_prefix_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  assign rows = clamp_dim(grid_rows_q, MAX_ROWS);
  assign cols = clamp_dim(grid_cols_q, MAX_COLS);

  // A load after a finished grid, or from a stale position, starts a new grid.
  assign restart = ready_q || (DIM_W'(load_row_q) >= rows) || (DIM_W'(load_col_q) >= cols);
  assign eff_row = restart ? '0 : load_row_q;
  assign eff_col = restart ? '0 : load_col_q;
  assign ext_val = {{(SUM_W-VAL_W){cell_value_i[VAL_W-1]}}, cell_value_i};

  assign bad_cmd = !ready_q || (top_row_i == '0) || (left_col_i == '0)
                || (bottom_row_i > rows) || (right_col_i > cols)
                || (top_row_i > bottom_row_i) || (left_col_i > right_col_i);

  assign fin_sum = (t_nz_q && l_nz_q) ? (acc_q + rdata) : acc_q;

  always_comb begin
    state_d     = state_q;
    grid_rows_d = grid_rows_q;
    grid_cols_d = grid_cols_q;
    load_row_d  = load_row_q;
    load_col_d  = load_col_q;
    rsum_d      = rsum_q;
    ready_d     = ready_q;
    done_d      = 1'b0;
    b0_d        = b0_q;
    r0_d        = r0_q;
    tm1_d       = tm1_q;
    lm1_d       = lm1_q;
    t_nz_d      = t_nz_q;
    l_nz_d      = l_nz_q;
    h_d         = h_q;
    w_d         = w_q;
    count_d     = count_q;
    acc_d       = acc_q;
    cover_d     = cover_q;
    bad_d       = bad_q;
    sum_d       = sum_q;

    mem_req.we    = 1'b0;
    mem_req.waddr = {load_row_q, load_col_q};
    mem_req.wdata = rsum_q + ((load_row_q != '0) ? rdata : '0);
    mem_req.raddr = {ROW_W'(bottom_row_i - DIM_W'(1)), COL_W'(right_col_i - DIM_W'(1))};

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (op_e'(opcode_i) == OP_LOAD)) begin
          // read the word above while the row sum advances
          mem_req.raddr = {eff_row - ROW_W'(1), eff_col};
          load_row_d    = eff_row;
          load_col_d    = eff_col;
          rsum_d        = ((eff_col == '0) ? '0 : rsum_q) + ext_val;
          ready_d       = 1'b0;
          state_d       = ST_LD_WR;
        end else if (accept) begin
          if (bad_cmd) begin
            done_d  = 1'b1;
            cover_d = 1'b0;
            sum_d   = '0;
            bad_d   = 1'b1;
          end else begin
            b0_d    = ROW_W'(bottom_row_i - DIM_W'(1));
            r0_d    = COL_W'(right_col_i - DIM_W'(1));
            tm1_d   = ROW_W'(top_row_i - DIM_W'(2));
            lm1_d   = COL_W'(left_col_i - DIM_W'(2));
            t_nz_d  = (top_row_i > DIM_W'(1));
            l_nz_d  = (left_col_i > DIM_W'(1));
            h_d     = bottom_row_i - top_row_i + DIM_W'(1);
            w_d     = right_col_i - left_col_i + DIM_W'(1);
            state_d = ST_Q_RD1;
          end
        end
      end
      ST_LD_WR: begin
        mem_req.we = 1'b1;
        if ((DIM_W'(load_col_q) + DIM_W'(1)) >= cols) begin
          load_col_d = '0;
          if ((DIM_W'(load_row_q) + DIM_W'(1)) >= rows) begin
            load_row_d = '0;
            ready_d    = 1'b1;
          end else begin
            load_row_d = load_row_q + ROW_W'(1);
          end
        end else begin
          load_col_d = load_col_q + COL_W'(1);
        end
        state_d = ST_IDLE;
      end
      ST_Q_RD1: begin
        mem_req.raddr = {tm1_q, r0_q};
        acc_d         = rdata;
        count_d       = CNT_W'(h_q) * CNT_W'(w_q);
        state_d       = ST_Q_RD2;
      end
      ST_Q_RD2: begin
        mem_req.raddr = {b0_q, lm1_q};
        acc_d         = t_nz_q ? (acc_q - rdata) : acc_q;
        state_d       = ST_Q_RD3;
      end
      ST_Q_RD3: begin
        mem_req.raddr = {tm1_q, lm1_q};
        acc_d         = l_nz_q ? (acc_q - rdata) : acc_q;
        state_d       = ST_Q_FIN;
      end
      ST_Q_FIN: begin
        done_d  = 1'b1;
        sum_d   = fin_sum;
        cover_d = !fin_sum[SUM_W-1] && (fin_sum == {{(SUM_W-CNT_W){1'b0}}, count_q});
        bad_d   = 1'b0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // a write to either grid register restarts loading
    if (cfg_wr && ((cfg_index_i == REG_GRID_ROWS) || (cfg_index_i == REG_GRID_COLS))) begin
      if (cfg_index_i == REG_GRID_ROWS) begin
        grid_rows_d = cfg_wdata_i;
      end else begin
        grid_cols_d = cfg_wdata_i;
      end
      load_row_d = '0;
      load_col_d = '0;
      rsum_d     = '0;
      ready_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grid_rows_q <= GRID_RESET;
      grid_cols_q <= GRID_RESET;
      load_row_q  <= '0;
      load_col_q  <= '0;
      rsum_q      <= '0;
      ready_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      grid_rows_q <= grid_rows_d;
      grid_cols_q <= grid_cols_d;
      load_row_q  <= load_row_d;
      load_col_q  <= load_col_d;
      rsum_q      <= rsum_d;
      ready_q     <= ready_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q    <= b0_d;
    r0_q    <= r0_d;
    tm1_q   <= tm1_d;
    lm1_q   <= lm1_d;
    t_nz_q  <= t_nz_d;
    l_nz_q  <= l_nz_d;
    h_q     <= h_d;
    w_q     <= w_d;
    count_q <= count_d;
    acc_q   <= acc_d;
    cover_q <= cover_d;
    bad_q   <= bad_d;
    sum_q   <= sum_d;
  end

  assign done_o        = done_q;
  assign all_covered_o = cover_q;
  assign rect_sum_o    = sum_q;
  assign bad_query_o   = bad_q;

  `SAT_ASSERT_ALWAYS(a_done_idle, done_o |-> !busy)
  `SAT_ASSERT(a_bad_clean, (done_o && bad_query_o) |-> (rect_sum_o == '0 && !all_covered_o))
  `SAT_ASSERT(a_load_silent, (start && !busy && (op_e'(opcode_i) == OP_LOAD)) |=> !done_o)
  `SAT_ASSERT(a_write_after_load, mem_req.we |-> $past(state_q) == ST_IDLE)

endmodule

### tb/sv/summed_area_rect_query_core_test.sv
`timescale 1ns / 1ps
module summed_area_rect_query_core_test;
  import sat_pkg::*;

  localparam int LOAD_SETTLE  = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 170;
  localparam int GRID_CELLS   = MAX_ROWS * MAX_COLS;

  // Indexes past the register list; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum int {
    FILL_RANDOM,
    FILL_EXTREME,
    FILL_ONES,
    FILL_SMALL
  } fill_e;

  typedef struct {
    logic covered;
    sum_t sum;
    logic bad;
  } rect_answer_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    opcode_i = OP_LOAD;
  logic signed [VAL_W-1:0] cell_value_i = '0;
  logic [DIM_W-1:0]        top_row_i = '0;
  logic [DIM_W-1:0]        left_col_i = '0;
  logic [DIM_W-1:0]        bottom_row_i = '0;
  logic [DIM_W-1:0]        right_col_i = '0;
  logic                    done_o;
  logic                    all_covered_o;
  logic signed [SUM_W-1:0] rect_sum_o;
  logic                    bad_query_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [DIM_W-1:0]        cfg_wdata_i = '0;

  summed_area_rect_query_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .cell_value_i (cell_value_i),
    .top_row_i    (top_row_i),
    .left_col_i   (left_col_i),
    .bottom_row_i (bottom_row_i),
    .right_col_i  (right_col_i),
    .done_o       (done_o),
    .all_covered_o(all_covered_o),
    .rect_sum_o   (rect_sum_o),
    .bad_query_o  (bad_query_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the table and load position.
  sum_t             shadow_prefix [GRID_CELLS];
  sum_t             shadow_row_sum = '0;
  int               shadow_row = 0;
  int               shadow_col = 0;
  logic             shadow_ready = 1'b0;
  logic [DIM_W-1:0] shadow_rows_reg = GRID_RESET;
  logic [DIM_W-1:0] shadow_cols_reg = GRID_RESET;

  rect_answer_t answer_queue [$];
  int           n_errors = 0;
  int           cycle_count = 0;
  logic         quiet_phase = 1'b0;

  function automatic int eff_dim(logic [DIM_W-1:0] v, int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int pick_gap();
    int roll;
    if (quiet_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_cell(fill_e mode);
    case (mode)
      FILL_EXTREME: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      FILL_ONES:    return ($urandom_range(0, 9) != 0) ? 16'sd1 : VAL_W'($urandom_range(0, 2));
      FILL_SMALL:   return VAL_W'(int'($urandom_range(0, 7)) - 3);
      default:      return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    if ($urandom_range(0, 99) < 15) return DIM_W'($urandom_range(0, 127));
    return DIM_W'($urandom_range(1, 8));
  endfunction

  // Keeps one side of a random grid short so a fill stays small.
  function automatic logic [DIM_W-1:0] pick_narrow();
    return DIM_W'($urandom_range(0, 2));
  endfunction

  task automatic restart_shadow();
    shadow_row_sum = '0;
    shadow_row = 0;
    shadow_col = 0;
    shadow_ready = 1'b0;
  endtask

  task automatic shadow_load(logic signed [VAL_W-1:0] v);
    int   rows;
    int   cols;
    sum_t entry;
    rows = eff_dim(shadow_rows_reg, MAX_ROWS);
    cols = eff_dim(shadow_cols_reg, MAX_COLS);
    if (shadow_ready) restart_shadow();
    if (shadow_row >= rows || shadow_col >= cols) begin
      shadow_row = 0;
      shadow_col = 0;
    end
    if (shadow_col == 0) shadow_row_sum = '0;
    shadow_row_sum = shadow_row_sum + {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
    entry = shadow_row_sum;
    if (shadow_row > 0) entry = entry + shadow_prefix[(shadow_row-1)*MAX_COLS + shadow_col];
    shadow_prefix[shadow_row*MAX_COLS + shadow_col] = entry;
    shadow_col++;
    if (shadow_col >= cols) begin
      shadow_col = 0;
      shadow_row++;
      if (shadow_row >= rows) begin
        shadow_row = 0;
        shadow_ready = 1'b1;
      end
    end
  endtask

  task automatic shadow_query(logic [DIM_W-1:0] t, logic [DIM_W-1:0] l,
                              logic [DIM_W-1:0] b, logic [DIM_W-1:0] r);
    int           rows;
    int           cols;
    int           ti, li, bi, ri;
    int           count;
    sum_t         acc;
    rect_answer_t ans;
    rows = eff_dim(shadow_rows_reg, MAX_ROWS);
    cols = eff_dim(shadow_cols_reg, MAX_COLS);
    if (!shadow_ready || t < 1 || l < 1 || int'(b) > rows || int'(r) > cols || t > b || l > r)
    begin
      ans.covered = 1'b0;
      ans.sum = '0;
      ans.bad = 1'b1;
    end else begin
      ti = int'(t) - 1;
      li = int'(l) - 1;
      bi = int'(b) - 1;
      ri = int'(r) - 1;
      acc = shadow_prefix[bi*MAX_COLS + ri];
      if (ti > 0) acc = acc - shadow_prefix[(ti-1)*MAX_COLS + ri];
      if (li > 0) acc = acc - shadow_prefix[bi*MAX_COLS + li - 1];
      if (ti > 0 && li > 0) acc = acc + shadow_prefix[(ti-1)*MAX_COLS + li - 1];
      count = (bi - ti + 1) * (ri - li + 1);
      ans.covered = !acc[SUM_W-1] && (acc == sum_t'(count));
      ans.sum = acc;
      ans.bad = 1'b0;
    end
    answer_queue = {answer_queue, ans};
  endtask

  // Leaves start high after the accept; the next call lowers it or reuses it.
  task automatic send_command(op_e op, logic signed [VAL_W-1:0] v,
                              logic [DIM_W-1:0] t, logic [DIM_W-1:0] l,
                              logic [DIM_W-1:0] b, logic [DIM_W-1:0] r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    opcode_i     <= op;
    cell_value_i <= v;
    top_row_i    <= t;
    left_col_i   <= l;
    bottom_row_i <= b;
    right_col_i  <= r;
    do @(posedge clk_i); while (busy);
    if (op == OP_LOAD) shadow_load(v);
    else shadow_query(t, l, b, r);
  endtask

  task automatic send_load(logic signed [VAL_W-1:0] v);
    send_command(OP_LOAD, v, DIM_W'($urandom), DIM_W'($urandom),
                 DIM_W'($urandom), DIM_W'($urandom));
  endtask

  task automatic send_query(logic [DIM_W-1:0] t, logic [DIM_W-1:0] l,
                            logic [DIM_W-1:0] b, logic [DIM_W-1:0] r);
    send_command(OP_QUERY, VAL_W'($urandom), t, l, b, r);
  endtask

  task automatic send_valid_query();
    int rows;
    int cols;
    int t, l;
    rows = eff_dim(shadow_rows_reg, MAX_ROWS);
    cols = eff_dim(shadow_cols_reg, MAX_COLS);
    t = $urandom_range(1, rows);
    l = $urandom_range(1, cols);
    send_query(DIM_W'(t), DIM_W'(l), DIM_W'($urandom_range(rows, t)),
               DIM_W'($urandom_range(cols, l)));
  endtask

  task automatic send_noise_query();
    send_query(DIM_W'($urandom_range(0, 127)), DIM_W'($urandom_range(0, 127)),
               DIM_W'($urandom_range(0, 127)), DIM_W'($urandom_range(0, 127)));
  endtask

  // Hold off until every answer is in and the last load has settled.
  task automatic drain();
    start <= 1'b0;
    while (answer_queue.size() != 0) @(posedge clk_i);
    repeat (LOAD_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    int gap;
    drain();
    gap = pick_gap();
    repeat (gap) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_GRID_ROWS) begin
      shadow_rows_reg = data;
      restart_shadow();
    end else if (idx == REG_GRID_COLS) begin
      shadow_cols_reg = data;
      restart_shadow();
    end
  endtask

  // Load up to the end of the current grid; stray queries land mid-load.
  task automatic fill_grid(fill_e mode, logic strays, output int sent);
    int rows;
    int cols;
    int left;
    rows = eff_dim(shadow_rows_reg, MAX_ROWS);
    cols = eff_dim(shadow_cols_reg, MAX_COLS);
    left = shadow_ready ? rows * cols : rows * cols - (shadow_row * cols + shadow_col);
    sent = 0;
    repeat (left) begin
      if (strays && $urandom_range(0, 19) == 0) begin
        send_noise_query();
        sent++;
      end
      send_load(pick_cell(mode));
      sent++;
    end
  endtask

  task automatic test_query_before_ready();
    send_query(7'd1, 7'd1, 7'd1, 7'd1);
    send_query(7'd64, 7'd64, 7'd64, 7'd64);
    send_query(7'd0, 7'd0, 7'd127, 7'd127);
  endtask

  task automatic test_extreme_grids();
    // Full-height column: reaches the last row address.
    write_reg(REG_GRID_ROWS, 7'd64);
    write_reg(REG_GRID_COLS, 7'd1);
    repeat (MAX_ROWS) send_load(16'sh7FFF);
    send_query(7'd1, 7'd1, 7'd64, 7'd1);
    send_query(7'd64, 7'd1, 7'd64, 7'd1);
    send_query(7'd1, 7'd1, 7'd1, 7'd1);
    send_query(7'd2, 7'd1, 7'd40, 7'd1);
    send_query(7'd0, 7'd1, 7'd64, 7'd1);
    send_query(7'd1, 7'd0, 7'd64, 7'd1);
    send_query(7'd1, 7'd1, 7'd65, 7'd1);
    send_query(7'd1, 7'd1, 7'd64, 7'd2);
    send_query(7'd10, 7'd1, 7'd9, 7'd1);
    send_query(7'd1, 7'd2, 7'd64, 7'd1);
    send_query(7'd127, 7'd127, 7'd127, 7'd127);
    // Full-width row: reaches the last column address.
    write_reg(REG_GRID_ROWS, 7'd1);
    write_reg(REG_GRID_COLS, 7'd64);
    repeat (MAX_COLS) send_load(16'sh8000);
    send_query(7'd1, 7'd1, 7'd1, 7'd64);
    send_query(7'd1, 7'd64, 7'd1, 7'd64);
    send_query(7'd1, 7'd2, 7'd1, 7'd63);
    send_query(7'd1, 7'd1, 7'd2, 7'd64);
    send_query(7'd1, 7'd1, 7'd1, 7'd65);
    // A load after ready opens a new grid and clears ready.
    send_load(16'sh7FFF);
    send_query(7'd1, 7'd1, 7'd1, 7'd1);
    repeat (MAX_COLS - 1) send_load(16'sh7FFF);
    send_query(7'd1, 7'd1, 7'd1, 7'd64);
    send_query(7'd1, 7'd33, 7'd1, 7'd64);
  endtask

  task automatic test_cover_flag();
    int sent;
    write_reg(REG_GRID_ROWS, 7'd3);
    write_reg(REG_GRID_COLS, 7'd5);
    repeat (15) send_load(16'sd1);
    send_query(7'd1, 7'd1, 7'd3, 7'd5);
    send_query(7'd2, 7'd2, 7'd3, 7'd4);
    // Zero acts as one row, oversize saturates to the full width.
    write_reg(REG_GRID_ROWS, 7'd0);
    write_reg(REG_GRID_COLS, 7'd100);
    fill_grid(FILL_ONES, 1'b0, sent);
    send_query(7'd1, 7'd1, 7'd1, 7'd64);
    send_query(7'd1, 7'd64, 7'd1, 7'd64);
    send_query(7'd1, 7'd1, 7'd2, 7'd64);
    send_query(7'd1, 7'd1, 7'd1, 7'd65);
  endtask

  task automatic test_spare_index();
    int sent;
    write_reg(REG_GRID_ROWS, 7'd2);
    write_reg(REG_GRID_COLS, 7'd2);
    fill_grid(FILL_RANDOM, 1'b0, sent);
    write_reg(REG_SPARE_2, 7'd127);
    write_reg(REG_SPARE_3, 7'd85);
    send_query(7'd1, 7'd1, 7'd2, 7'd2);
    send_query(7'd2, 7'd1, 7'd2, 7'd2);
  endtask

  task automatic test_restart_on_write();
    int sent;
    write_reg(REG_GRID_ROWS, 7'd4);
    write_reg(REG_GRID_COLS, 7'd4);
    repeat (7) send_load(pick_cell(FILL_RANDOM));
    send_query(7'd1, 7'd1, 7'd1, 7'd1);
    write_reg(REG_GRID_COLS, 7'd4);
    fill_grid(FILL_SMALL, 1'b0, sent);
    send_query(7'd1, 7'd1, 7'd4, 7'd4);
    write_reg(REG_GRID_ROWS, 7'd4);
    send_query(7'd1, 7'd1, 7'd4, 7'd4);
  endtask

  task automatic test_random_mix();
    int    items;
    int    sent;
    int    nq;
    fill_e mode;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      quiet_phase = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          write_reg(REG_GRID_ROWS, pick_dim());
          write_reg(REG_GRID_COLS, pick_narrow());
        end else begin
          write_reg(REG_GRID_ROWS, pick_narrow());
          write_reg(REG_GRID_COLS, pick_dim());
        end
      end
      mode = fill_e'($urandom_range(0, 3));
      fill_grid(mode, 1'b1, sent);
      items += sent;
      nq = $urandom_range(3, 12);
      repeat (nq) begin
        if ($urandom_range(0, 9) < 7) send_valid_query();
        else send_noise_query();
        items++;
      end
      if ($urandom_range(0, 4) == 0) begin
        send_load(pick_cell(mode));
        send_noise_query();
        items += 2;
      end
      if ($urandom_range(0, 7) == 0) drain();
    end
    quiet_phase = 1'b0;
  endtask

  always @(posedge clk_i) begin : check_answers
    rect_answer_t want;
    if (rst_ni && done_o) begin
      if (answer_queue.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected word covered=%0b sum=%0d bad=%0b", $time,
                 all_covered_o, rect_sum_o, bad_query_o);
      end else begin
        want = answer_queue.pop_front();
        if (all_covered_o !== want.covered || rect_sum_o !== want.sum ||
            bad_query_o !== want.bad) begin
          n_errors++;
          $display("%0t: mismatch expected covered=%0b sum=%0d bad=%0b, got %0b %0d %0b",
                   $time, want.covered, $signed(want.sum), want.bad,
                   all_covered_o, rect_sum_o, bad_query_o);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout with %0d answers pending", $time, answer_queue.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_query_before_ready();
    test_extreme_grids();
    test_cover_flag();
    test_spare_index();
    test_restart_on_write();
    test_random_mix();
    drain();
    if (n_errors == 0 && answer_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
